// File: hw/rtl/gocs_pkg.sv
`default_nettype none

package gocs_pkg;

    localparam int TIMER_W  = 16;
    localparam int PERIOD_W = 8;
    localparam int PHASE_W  = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_PERIOD    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIODS_TO_MOVE = 1'd1;

    localparam logic [TIMER_W-1:0]  TIMER_PERIOD_RST    = 16'd1000;
    localparam logic [PERIOD_W-1:0] PERIODS_TO_MOVE_RST = 8'd10;
    localparam logic [TIMER_W-1:0]  TICK_MAX            = 16'hFFFF;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX          = 8'hFF;

    localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_WAIT   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_PULSE  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_SETTLE = 2'd3;

    typedef struct packed {
        logic open_sw;
        logic close_sw;
        logic tick;
    } t_item;

    typedef struct packed {
        logic                open_req;
        logic                close_req;
        logic                moving_open;
        logic                moving_close;
        logic [PHASE_W-1:0]  phase;
        logic [PERIOD_W-1:0] period_count;
        logic [TIMER_W-1:0]  tick_count;
        logic                lamp;
        logic                drv_open;
        logic                drv_close;
        logic                drv_reset;
    } t_state;

    localparam t_state STATE_RST = '{
        open_req:     1'b0,
        close_req:    1'b0,
        moving_open:  1'b0,
        moving_close: 1'b0,
        phase:        PH_IDLE,
        period_count: '0,
        tick_count:   '0,
        lamp:         1'b0,
        drv_open:     1'b0,
        drv_close:    1'b0,
        drv_reset:    1'b0
    };

endpackage

`default_nettype wire

// File: hw/rtl/gocs_in_stage.sv
`default_nettype none

module gocs_in_stage
    import gocs_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_stall,
    input  wire   i_open_switch,
    input  wire   i_close_switch,
    input  wire   i_tick,
    input  wire   i_advance,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_accept;

    assign o_in_stall = r_valid && !i_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= '{open_sw: i_open_switch, close_sw: i_close_switch, tick: i_tick};
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// File: hw/rtl/gocs_step.sv
`default_nettype none

module gocs_step
    import gocs_pkg::*;
(
    input  wire t_item          i_item,
    input  wire t_state         i_state,
    input  wire [TIMER_W-1:0]   i_timer_period,
    input  wire [PERIOD_W-1:0]  i_periods_to_move,
    output t_state              o_state
);

    function automatic t_state f_count(input t_state s, input logic [TIMER_W-1:0] tp);
        t_state t;
        t = s;
        if (t.tick_count >= tp) begin
            t.tick_count = '0;
            if (t.period_count != PERIOD_MAX) begin
                t.period_count = t.period_count + 8'd1;
            end
        end
        return t;
    endfunction

    always_comb begin
        t_state s;
        s = i_state;
        if (i_item.tick && s.tick_count != TICK_MAX) begin
            s.tick_count = s.tick_count + 16'd1;
        end

        // open side
        if (i_item.open_sw && !s.open_req && s.phase == PH_IDLE && !s.close_req) begin
            s.lamp         = 1'b1;
            s.open_req     = 1'b1;
            s.period_count = '0;
            s.tick_count   = '0;
        end else if (!i_item.open_sw && s.open_req && !s.moving_open) begin
            s.lamp         = 1'b0;
            s.open_req     = 1'b0;
            s.period_count = '0;
        end else if (!i_item.open_sw && s.moving_open) begin
            s.drv_open    = 1'b0;
            s.open_req    = 1'b0;
            s.moving_open = 1'b0;
            s.phase       = PH_WAIT;
            s.tick_count  = '0;
        end
        if (s.open_req && !s.moving_open) begin
            s = f_count(s, i_timer_period);
            if (s.period_count >= i_periods_to_move) begin
                s.drv_open     = 1'b1;
                s.moving_open  = 1'b1;
                s.period_count = '0;
            end
        end

        // close side
        if (i_item.close_sw && !s.close_req && s.phase == PH_IDLE && !s.open_req) begin
            s.lamp         = 1'b1;
            s.close_req    = 1'b1;
            s.period_count = '0;
            s.tick_count   = '0;
        end else if (!i_item.close_sw && s.close_req && !s.moving_close) begin
            s.lamp         = 1'b0;
            s.close_req    = 1'b0;
            s.period_count = '0;
        end else if (!i_item.close_sw && s.moving_close) begin
            s.drv_close    = 1'b0;
            s.close_req    = 1'b0;
            s.moving_close = 1'b0;
            s.phase        = PH_WAIT;
            s.tick_count   = '0;
        end
        if (s.close_req && !s.moving_close) begin
            s = f_count(s, i_timer_period);
            if (s.period_count >= i_periods_to_move) begin
                s.drv_close    = 1'b1;
                s.moving_close = 1'b1;
                s.period_count = '0;
            end
        end

        // end sequence
        case (s.phase)
            PH_WAIT: begin
                s = f_count(s, i_timer_period);
                if (s.period_count >= i_periods_to_move) begin
                    s.lamp         = 1'b0;
                    s.drv_reset    = 1'b1;
                    s.period_count = '0;
                    s.phase        = PH_PULSE;
                end
            end
            PH_PULSE: begin
                if (s.tick_count >= i_timer_period) begin
                    s.tick_count = '0;
                    s.drv_reset  = 1'b0;
                    s.phase      = PH_SETTLE;
                end
            end
            PH_SETTLE: begin
                s = f_count(s, i_timer_period);
                if (s.period_count >= i_periods_to_move) begin
                    s.period_count = '0;
                    s.phase        = PH_IDLE;
                end
            end
            default: begin
            end
        endcase

        o_state = s;
    end

endmodule

`default_nettype wire

// File: hw/rtl/gate_open_close_sequencer.sv
// path: each input transaction is registered in the input stage, then its result in the state register
// throughput: one transaction per cycle while the output is not stalled, set by the combinational state update
// output stall holds the result in the state register; one item waits in the input stage
// reset (synchronous, active low): sequencer idle, all drive and lamp levels off,
// timer period 1000 ticks, 10 periods to move
`default_nettype none

module gate_open_close_sequencer
    import gocs_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire                   i_open_switch,
    input  wire                   i_close_switch,
    input  wire                   i_tick,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output logic                  o_lamp_on,
    output logic                  o_drive_open,
    output logic                  o_drive_close,
    output logic                  o_drive_reset,
    output logic [PHASE_W-1:0]    o_end_phase,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data
);

    logic                r_out_valid;
    t_state              r_state;
    t_state              n_state;
    logic [TIMER_W-1:0]  r_timer_period;
    logic [PERIOD_W-1:0] r_periods_to_move;
    logic                w_out_free;
    logic                w_fire;
    logic                w_item_valid;
    t_item               w_item;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = w_item_valid && w_out_free;

    gocs_in_stage u_in (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_open_switch  (i_open_switch),
        .i_close_switch (i_close_switch),
        .i_tick         (i_tick),
        .i_advance      (w_out_free),
        .o_valid        (w_item_valid),
        .o_item         (w_item)
    );

    gocs_step u_step (
        .i_item            (w_item),
        .i_state           (r_state),
        .i_timer_period    (r_timer_period),
        .i_periods_to_move (r_periods_to_move),
        .o_state           (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_period    <= TIMER_PERIOD_RST;
            r_periods_to_move <= PERIODS_TO_MOVE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TIMER_PERIOD:    r_timer_period    <= i_cfg_data;
                CFG_PERIODS_TO_MOVE: r_periods_to_move <= i_cfg_data[PERIOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_state <= n_state;
            end
            if (w_out_free) begin
                r_out_valid <= w_fire;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_lamp_on     = r_state.lamp;
    assign o_drive_open  = r_state.drv_open;
    assign o_drive_close = r_state.drv_close;
    assign o_drive_reset = r_state.drv_reset;
    assign o_end_phase   = r_state.phase;

endmodule

`default_nettype wire

// File: hw/rtl/gocs_checker.sv
`default_nettype none

module gocs_checker
    import gocs_pkg::*;
(
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               o_out_valid,
    input wire               i_out_stall,
    input wire               o_lamp_on,
    input wire               o_drive_open,
    input wire               o_drive_close,
    input wire               o_drive_reset,
    input wire [PHASE_W-1:0] o_end_phase
);

    // drives exclude each other
    a_drive_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_drive_open && o_drive_close))
        else $error("open and close drive both on");

    // reset pulse only in its own phase
    a_reset_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_drive_reset == (o_end_phase == PH_PULSE)))
        else $error("drive reset level and end phase disagree");

    // no drive while the end sequence runs
    a_no_drive_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_phase != PH_IDLE) |-> (!o_drive_open && !o_drive_close))
        else $error("drive on during end sequence");

    // stalled transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_lamp_on)
            && $stable(o_drive_open) && $stable(o_drive_close)
            && $stable(o_drive_reset) && $stable(o_end_phase)))
        else $error("stalled result changed");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind gate_open_close_sequencer gocs_checker u_gocs_checker (.*);

`default_nettype wire

// File: verif/tb_gate_open_close_sequencer.sv
module tb_gate_open_close_sequencer;
    import gocs_pkg::*;

    localparam int TIMEOUT_UNITS = 1_000_000;
    localparam int PHASE_ITEMS   = 140;
    localparam int RANDOM_PHASES = 12;

    typedef struct packed {
        logic               lamp;
        logic               drv_open;
        logic               drv_close;
        logic               drv_reset;
        logic [PHASE_W-1:0] phase;
    } t_gate_levels;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  i_open_switch  = 1'b0;
    logic                  i_close_switch = 1'b0;
    logic                  i_tick         = 1'b0;
    logic                  i_out_stall    = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx      = CFG_TIMER_PERIOD;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_lamp_on;
    logic                  o_drive_open;
    logic                  o_drive_close;
    logic                  o_drive_reset;
    logic [PHASE_W-1:0]    o_end_phase;

    gate_open_close_sequencer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_open_switch  (i_open_switch),
        .i_close_switch (i_close_switch),
        .i_tick         (i_tick),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_lamp_on      (o_lamp_on),
        .o_drive_open   (o_drive_open),
        .o_drive_close  (o_drive_close),
        .o_drive_reset  (o_drive_reset),
        .o_end_phase    (o_end_phase),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // gate sequencer prediction state
    logic [TIMER_W-1:0]  cfg_timer_period = TIMER_PERIOD_RST;
    logic [PERIOD_W-1:0] cfg_moves        = PERIODS_TO_MOVE_RST;
    logic                gate_open_req    = 1'b0;
    logic                gate_close_req   = 1'b0;
    logic                gate_moving_open = 1'b0;
    logic                gate_moving_close = 1'b0;
    logic [PHASE_W-1:0]  gate_phase       = PH_IDLE;
    logic [PERIOD_W-1:0] gate_periods     = '0;
    logic [TIMER_W-1:0]  gate_ticks       = '0;
    t_gate_levels        gate_levels      = '0;

    t_item        pending_items[$];
    t_gate_levels expected_levels[$];
    t_item        offered;
    t_gate_levels want;

    int  fault_count    = 0;
    int  items_accepted = 0;
    int  results_seen   = 0;
    int  settings_used  = 0;
    int  drive_starts   = 0;
    int  end_sequences  = 0;
    int  burst_left     = 0;
    int  gap_left       = 0;
    int  hold_left      = 0;
    int  mode_left      = 0;
    int  stall_mode     = 0;
    bit  steady_send    = 1'b0;
    bit  long_hold_wanted = 1'b0;
    bit  long_hold_done = 1'b0;

    function logic timer_lapsed();
        if (gate_ticks >= cfg_timer_period) begin
            gate_ticks = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function void bump_periods();
        if (timer_lapsed() && gate_periods < PERIOD_MAX)
            gate_periods++;
    endfunction

    function t_gate_levels advance_gate(input t_item it);
        if (it.tick && gate_ticks != TICK_MAX)
            gate_ticks++;

        // open side first
        if (it.open_sw && !gate_open_req && gate_phase == PH_IDLE && !gate_close_req) begin
            gate_levels.lamp = 1'b1;
            gate_open_req = 1'b1;
            gate_periods = '0;
            gate_ticks = '0;
        end else if (!it.open_sw && gate_open_req && !gate_moving_open) begin
            gate_levels.lamp = 1'b0;
            gate_open_req = 1'b0;
            gate_periods = '0;
        end else if (!it.open_sw && gate_moving_open) begin
            gate_levels.drv_open = 1'b0;
            gate_open_req = 1'b0;
            gate_moving_open = 1'b0;
            gate_phase = PH_WAIT;
            gate_ticks = '0;
        end
        if (gate_open_req && !gate_moving_open) begin
            bump_periods();
            if (gate_periods >= cfg_moves) begin
                gate_levels.drv_open = 1'b1;
                gate_moving_open = 1'b1;
                gate_periods = '0;
                drive_starts++;
            end
        end

        if (it.close_sw && !gate_close_req && gate_phase == PH_IDLE && !gate_open_req) begin
            gate_levels.lamp = 1'b1;
            gate_close_req = 1'b1;
            gate_periods = '0;
            gate_ticks = '0;
        end else if (!it.close_sw && gate_close_req && !gate_moving_close) begin
            gate_levels.lamp = 1'b0;
            gate_close_req = 1'b0;
            gate_periods = '0;
        end else if (!it.close_sw && gate_moving_close) begin
            gate_levels.drv_close = 1'b0;
            gate_close_req = 1'b0;
            gate_moving_close = 1'b0;
            gate_phase = PH_WAIT;
            gate_ticks = '0;
        end
        if (gate_close_req && !gate_moving_close) begin
            bump_periods();
            if (gate_periods >= cfg_moves) begin
                gate_levels.drv_close = 1'b1;
                gate_moving_close = 1'b1;
                gate_periods = '0;
                drive_starts++;
            end
        end

        case (gate_phase)
            PH_WAIT: begin
                bump_periods();
                if (gate_periods >= cfg_moves) begin
                    gate_levels.lamp = 1'b0;
                    gate_levels.drv_reset = 1'b1;
                    gate_periods = '0;
                    gate_phase = PH_PULSE;
                end
            end
            PH_PULSE: begin
                if (timer_lapsed()) begin
                    gate_levels.drv_reset = 1'b0;
                    gate_phase = PH_SETTLE;
                end
            end
            PH_SETTLE: begin
                bump_periods();
                if (gate_periods >= cfg_moves) begin
                    gate_periods = '0;
                    gate_phase = PH_IDLE;
                    end_sequences++;
                end
            end
            default: ;
        endcase

        gate_levels.phase = gate_phase;
        return gate_levels;
    endfunction

    task automatic report_fault(input string msg);
        if (fault_count < 40)
            $display("ERROR at %0t: %s", $realtime, msg);
        fault_count++;
    endtask

    task automatic check_field(input string name, input int got, input int exp_val);
        if (got != exp_val)
            report_fault($sformatf("result %0d %s got %0d want %0d",
                                   results_seen, name, got, exp_val));
    endtask

    // sender: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_levels.push_back(advance_gate(offered));
                items_accepted++;
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (gap_left == 0 && pending_items.size() != 0) begin
                    offered = pending_items.pop_front();
                    i_open_switch  <= offered.open_sw;
                    i_close_switch <= offered.close_sw;
                    i_tick         <= offered.tick;
                    i_in_valid     <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        if (steady_send || $urandom_range(0, 2) == 0)
                            gap_left = 0;
                        else
                            gap_left = $urandom_range(1, 5);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                    if (gap_left != 0)
                        gap_left--;
                end
            end
        end
    end

    // receiver stall pattern with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (long_hold_wanted && !long_hold_done) begin
            i_out_stall <= 1'b1;
            hold_left = 120;
            long_hold_done = 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (stall_mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                2:       i_out_stall <= 1'($urandom_range(0, 1));
                default: i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_levels.size() == 0) begin
                report_fault("result transaction with nothing expected");
            end else begin
                want = expected_levels.pop_front();
                check_field("lamp_on", int'(o_lamp_on), int'(want.lamp));
                check_field("drive_open", int'(o_drive_open), int'(want.drv_open));
                check_field("drive_close", int'(o_drive_close), int'(want.drv_close));
                check_field("drive_reset", int'(o_drive_reset), int'(want.drv_reset));
                check_field("end_phase", int'(o_end_phase), int'(want.phase));
            end
            results_seen++;
        end
    end

    task automatic push_passes(input bit open_sw, input bit close_sw, input int n,
                               input int tick_pct);
        t_item it;
        repeat (n) begin
            it.open_sw  = open_sw;
            it.close_sw = close_sw;
            it.tick     = ($urandom_range(1, 100) <= tick_pct);
            pending_items.push_back(it);
        end
    endtask

    // mostly press-hold-release sequences sized to the settings, some noise
    task automatic push_random_sequence();
        int span;
        int hold;
        int rest;
        int pct;
        int side;
        span = (int'(cfg_timer_period) + 1) * (int'(cfg_moves) + 1) + 2;
        if (span > 300)
            span = 300;
        pct = ($urandom_range(0, 2) == 0) ? $urandom_range(30, 90) : 100;
        side = $urandom_range(0, 9);
        if (side < 8) begin
            hold = $urandom_range(0, span + span / 2);
            rest = $urandom_range(0, 3 * span);
            if (rest > 300)
                rest = 300;
            if (side < 3)
                push_passes(1'b1, 1'b0, hold, pct);
            else if (side < 6)
                push_passes(1'b0, 1'b1, hold, pct);
            else if (side < 7)
                push_passes(1'b1, 1'b1, hold, pct);
            else begin
                push_passes(1'b1, 1'b0, hold, pct);
                push_passes(1'b1, 1'b1, $urandom_range(1, 8), pct);
                push_passes(1'b0, 1'b1, hold, pct);
            end
            push_passes(1'b0, 1'b0, rest, pct);
        end else begin
            repeat ($urandom_range(1, 12))
                push_passes(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            $urandom_range(1, 4), 50);
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || expected_levels.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] period,
                                  input logic [CFG_DATA_W-1:0] moves);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_TIMER_PERIOD;
        i_cfg_data <= period;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_PERIODS_TO_MOVE;
        i_cfg_data <= moves;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_timer_period = period;
        cfg_moves = moves[PERIOD_W-1:0];
        settings_used++;
        @(negedge i_clk);
    endtask

    initial begin
        #(TIMEOUT_UNITS);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: both switches from idle, open wins
        push_passes(1'b1, 1'b1, 3, 100);
        push_passes(1'b0, 1'b0, 2, 100);
        wait_drained();

        // zero period and zero wait: every step goes on without waiting for ticks
        apply_settings(16'd0, 16'd0);
        push_passes(1'b1, 1'b0, 2, 0);
        push_passes(1'b0, 1'b0, 4, 0);
        push_passes(1'b0, 1'b1, 2, 0);
        push_passes(1'b0, 1'b0, 3, 0);
        wait_drained();

        apply_settings(16'd1, 16'd2);
        push_passes(1'b1, 1'b0, 6, 100);
        push_passes(1'b0, 1'b0, 6, 100);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0:       apply_settings(16'd0, 16'd0);
                1:       apply_settings(16'd1, 16'd1);
                2:       apply_settings(16'd2, 16'd3);
                3:       apply_settings(16'd1, 16'd2);
                4:       apply_settings(16'd0, 16'd255);
                5:       apply_settings(16'hFFFF, 16'd255);
                6:       apply_settings(16'd3, 16'd0);
                7:       apply_settings(16'd0, {8'($urandom), 8'd1});
                default: apply_settings(16'($urandom_range(0, 4)),
                                        {8'($urandom), 8'($urandom_range(0, 4))});
            endcase
            steady_send = (ph == 3);
            while (pending_items.size() < PHASE_ITEMS)
                push_random_sequence();
            // keep every phase to the same item budget
            while (pending_items.size() > PHASE_ITEMS)
                void'(pending_items.pop_back());
            if (ph == 3)
                long_hold_wanted = 1'b1;
        end

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (expected_levels.size() != 0)
            report_fault($sformatf("%0d results never arrived", expected_levels.size()));

        $display("covered %0d transactions under %0d register settings", items_accepted,
                 settings_used);
        $display("saw %0d drive starts and %0d complete end sequences", drive_starts,
                 end_sequences);
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: gate_open_close_sequencer.f
hw/rtl/gocs_pkg.sv
hw/rtl/gocs_in_stage.sv
hw/rtl/gocs_step.sv
hw/rtl/gate_open_close_sequencer.sv
hw/rtl/gocs_checker.sv
verif/tb_gate_open_close_sequencer.sv
